// ===== hdl/scq_pkg.sv =====
// scale quantizer types, scale table and shared helper functions
`default_nettype none

package scq_pkg;

  // table geometry and note limits
  localparam int SCALE_COUNT     = 22;
  localparam int MAX_SCALE_LEN   = 12;
  localparam int ROM_ENTRIES     = 22;
  localparam int CHROMATIC_ENTRY = 21;
  localparam int NOTE_MAX        = 127;
  localparam int OCTAVE          = 12;
  localparam int SNAP_REACH      = 6;
  localparam int CFG_ADDR_W      = 3;

  // register indexes on the config port
  localparam logic REG_SCALE_SELECT = 1'b0;
  localparam logic REG_ROOT_NOTE    = 1'b1;

  typedef logic [11:0][3:0] step_row_t;

  // semitone offsets per scale, degree 0 in the lowest nibble
  localparam step_row_t SCALE_ROM [ROM_ENTRIES] = '{
    48'h00000B975420, 48'h00000B975320, 48'h00000B875320, 48'h000000097420,
    48'h0000000A7530, 48'h000000A76530, 48'h00000A965320, 48'h000000000740,
    48'h000000000730, 48'h00000000B740, 48'h00000000A730, 48'h00000B875410,
    48'h0000A8754310, 48'h00000B876320, 48'h00000A865420, 48'h0000000A7520,
    48'h000000097320, 48'h000000087310, 48'h000000087510, 48'h0000000B7540,
    48'h000000A86420, 48'hBA9876543210
  };

  localparam logic [3:0] SCALE_LEN [ROM_ENTRIES] = '{
    4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd6, 4'd7, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd7, 4'd8, 4'd7, 4'd7, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd12
  };

  typedef struct packed {
    logic signed [8:0] raw_degree;
    logic [6:0]        note_in;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  mapped_note;
    logic        in_scale;
    logic [6:0]  snapped_note;
    logic [11:0] scale_mask;
  } out_word_t;

  // x mod 12 for 7-bit x, quotient by reciprocal 43/512
  function automatic logic [3:0] mod12_7b(input logic [6:0] x);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  q12;
    logic [6:0]  r;
    prod = {6'd0, x} * 13'd43;
    q    = prod[12:9];
    q12  = ({3'd0, q} << 3) + ({3'd0, q} << 2);
    r    = x - q12;
    return r[3:0];
  endfunction

  // pitch-class mask of a scale relative to its root
  function automatic logic [11:0] rel_mask(input logic [4:0] idx, input logic [3:0] len);
    logic [11:0] m;
    step_row_t   row;
    m   = '0;
    row = SCALE_ROM[idx];
    for (int i = 0; i < MAX_SCALE_LEN; i++) begin
      if (4'(i) < len) begin
        m[row[i]] = 1'b1;
      end
    end
    return m;
  endfunction

  // ceil(2^16 / len), exact floor quotient for dividends below 3328
  function automatic logic [16:0] recip16(input logic [3:0] len);
    logic [16:0] r;
    case (len)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/scale_note_quantizer_core.sv =====
// scale note quantizer: config registers and four-stage result pipeline
// an accepted word passes the stage 1, 2, 3 and 4 registers in order to out_valid
// throughput: one word per cycle unless out_ready stalls; the stages are degree bias,
// reciprocal multiply, remainder, and note assembly, each behind its own register
// a stall on out_ready holds the last stage, earlier words close up into empty stages
// reset clears all stage valid bits, scale_select to 0 and root_note to 60
`default_nettype none

module scale_note_quantizer_core import scq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // config registers
  logic [4:0]  scale_select_r, scale_select_nxt;
  logic [6:0]  root_note_r, root_note_nxt;
  logic        reg_idx;

  // active scale, derived from config
  logic [4:0]  act_idx;
  logic [3:0]  len_rom;
  logic [3:0]  len;
  logic [11:0] rel;
  logic [3:0]  root_pc;
  logic [23:0] rot_wide;
  logic [11:0] rot_mask;

  // stage valid bits and ready chain
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, v4_r, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: biased degree, note pitch class
  logic [11:0] s1_u_r, s1_u_nxt;
  logic [6:0]  s1_note_r, s1_note_nxt;
  logic [3:0]  s1_pc_r, s1_pc_nxt;

  // stage 2: quotient, membership, snap
  logic [28:0] s2_prod;
  logic [11:0] s2_q_r, s2_q_nxt;
  logic [11:0] s2_u_r, s2_u_nxt;
  logic        s2_member_r, s2_member_nxt;
  logic [6:0]  s2_snap_r, s2_snap_nxt;

  // stage 3: remainder and octave
  logic [15:0]       s3_qlen;
  logic [11:0]       s3_rem;
  logic [3:0]        s3_d_r, s3_d_nxt;
  logic signed [9:0] s3_oct_r, s3_oct_nxt;
  logic              s3_member_r, s3_member_nxt;
  logic [6:0]        s3_snap_r, s3_snap_nxt;

  // stage 4: output word
  logic [3:0]         s4_step;
  logic signed [12:0] s4_sum;
  out_word_t          s4_word_r, s4_word_nxt;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_comb begin
    scale_select_nxt = scale_select_r;
    root_note_nxt    = root_note_r;
    if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SCALE_SELECT: scale_select_nxt = pwdata[4:0];
        REG_ROOT_NOTE:    root_note_nxt    = pwdata[6:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE_SELECT: prdata = {27'd0, scale_select_r};
      REG_ROOT_NOTE:    prdata = {25'd0, root_note_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_select_r <= 5'd0;
      root_note_r    <= 7'd60;
    end else begin
      scale_select_r <= scale_select_nxt;
      root_note_r    <= root_note_nxt;
    end
  end

  // active scale lookup and rotated mask
  always_comb begin
    act_idx = (scale_select_r >= 5'(SCALE_COUNT)) ? 5'(CHROMATIC_ENTRY) : scale_select_r;
    len_rom = SCALE_LEN[act_idx];
    if (len_rom > 4'(MAX_SCALE_LEN)) begin
      len = 4'(MAX_SCALE_LEN);
    end else if (len_rom == 4'd0) begin
      len = 4'd1;
    end else begin
      len = len_rom;
    end
    rel      = rel_mask(act_idx, len);
    root_pc  = mod12_7b(root_note_r);
    rot_wide = {rel, rel} << root_pc;
    rot_mask = rot_wide[23:12];
  end

  // ready chain, a stage moves when it is empty or the next one moves
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // stage 1: bias degree by 256*len so floor division stays unsigned
  always_comb begin
    s1_u_nxt    = {{3{in_data.raw_degree[8]}}, in_data.raw_degree} + {len, 8'd0};
    s1_note_nxt = in_data.note_in;
    s1_pc_nxt   = mod12_7b(in_data.note_in);
  end

  // stage 2: quotient by reciprocal multiply
  always_comb begin
    s2_prod  = 29'(s1_u_r) * 29'(recip16(len));
    s2_q_nxt = s2_prod[27:16];
    s2_u_nxt = s1_u_r;
  end

  // stage 2: membership and nearest scale note, near and upper side first
  always_comb begin : snap_search
    logic [7:0] up_note;
    logic [4:0] up_pc;
    logic [4:0] dn_pc;
    up_note       = '0;
    up_pc         = '0;
    dn_pc         = '0;
    s2_member_nxt = rot_mask[s1_pc_r];
    s2_snap_nxt   = s1_note_r;
    if (!s2_member_nxt) begin
      for (int k = SNAP_REACH; k >= 1; k--) begin
        up_note = {1'b0, s1_note_r} + 8'(k);
        up_pc   = {1'b0, s1_pc_r} + 5'(k);
        if (up_pc >= 5'(OCTAVE)) begin
          up_pc = up_pc - 5'(OCTAVE);
        end
        dn_pc = {1'b0, s1_pc_r} + 5'(OCTAVE) - 5'(k);
        if (dn_pc >= 5'(OCTAVE)) begin
          dn_pc = dn_pc - 5'(OCTAVE);
        end
        if (({1'b0, s1_note_r} >= 8'(k)) && rot_mask[dn_pc[3:0]]) begin
          s2_snap_nxt = s1_note_r - 7'(k);
        end
        if ((up_note <= 8'(NOTE_MAX)) && rot_mask[up_pc[3:0]]) begin
          s2_snap_nxt = up_note[6:0];
        end
      end
    end
  end

  // stage 3: remainder and unbiased octave
  always_comb begin
    s3_qlen       = 16'(s2_q_r) * 16'(len);
    s3_rem        = s2_u_r - s3_qlen[11:0];
    s3_d_nxt      = s3_rem[3:0];
    s3_oct_nxt    = 10'(s2_q_r - 12'd256);
    s3_member_nxt = s2_member_r;
    s3_snap_nxt   = s2_snap_r;
  end

  // stage 4: root + offset + 12*octave, saturated
  always_comb begin
    s4_step = SCALE_ROM[act_idx][s3_d_r];
    s4_sum  = 13'(root_note_r) + 13'(s4_step)
            + ({{3{s3_oct_r[9]}}, s3_oct_r} <<< 3) + ({{3{s3_oct_r[9]}}, s3_oct_r} <<< 2);
    if (s4_sum < 0) begin
      s4_word_nxt.mapped_note = 7'd0;
    end else if (s4_sum > 13'sd127) begin
      s4_word_nxt.mapped_note = 7'(NOTE_MAX);
    end else begin
      s4_word_nxt.mapped_note = s4_sum[6:0];
    end
    s4_word_nxt.in_scale     = s3_member_r;
    s4_word_nxt.snapped_note = s3_snap_r;
    s4_word_nxt.scale_mask   = rot_mask;
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_u_r    <= s1_u_nxt;
      s1_note_r <= s1_note_nxt;
      s1_pc_r   <= s1_pc_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_q_r      <= s2_q_nxt;
      s2_u_r      <= s2_u_nxt;
      s2_member_r <= s2_member_nxt;
      s2_snap_r   <= s2_snap_nxt;
    end
    if (rdy3 && v2_r) begin
      s3_d_r      <= s3_d_nxt;
      s3_oct_r    <= s3_oct_nxt;
      s3_member_r <= s3_member_nxt;
      s3_snap_r   <= s3_snap_nxt;
    end
    if (rdy4 && v3_r) begin
      s4_word_r <= s4_word_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_word_r;

  // remainder from the reciprocal divide is always below the scale size
  assert property (@(posedge clk) disable iff (!rst_n) v3_r |-> (s3_d_r < len))
    else $error("degree remainder out of range");

  // a note flagged in scale is its own snap and sits on a mask bit
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_scale) |-> out_data.scale_mask[mod12_7b(out_data.snapped_note)])
    else $error("in-scale note not on mask");

  // an accepted word always occupies the first stage next cycle
  assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> v1_r)
    else $error("accepted word dropped at stage 1");

endmodule

`default_nettype wire

// ===== tb/scale_note_quantizer_core_test.sv =====
// self-checking testbench for the scale note quantizer core
`timescale 1ns / 100ps

module scale_note_quantizer_core_test import scq_pkg::*; ();

  // scoreboard: predicts each result word and checks it in order
  class note_scoreboard;
    int        scale_sel;
    int        root;
    int        errors;
    out_word_t expected_q[$];
    int        offsets[22][12];
    int        sizes[22];

    function new();
      offsets = '{
        '{0, 2, 4, 5, 7, 9, 11, 0, 0, 0, 0, 0}, '{0, 2, 3, 5, 7, 9, 11, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 8, 11, 0, 0, 0, 0, 0}, '{0, 2, 4, 7, 9, 0, 0, 0, 0, 0, 0, 0},
        '{0, 3, 5, 7, 10, 0, 0, 0, 0, 0, 0, 0}, '{0, 3, 5, 6, 7, 10, 0, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 6, 9, 10, 0, 0, 0, 0, 0}, '{0, 4, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 3, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0}, '{0, 4, 7, 11, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 3, 7, 10, 0, 0, 0, 0, 0, 0, 0, 0}, '{0, 1, 4, 5, 7, 8, 11, 0, 0, 0, 0, 0},
        '{0, 1, 3, 4, 5, 7, 8, 10, 0, 0, 0, 0}, '{0, 2, 3, 6, 7, 8, 11, 0, 0, 0, 0, 0},
        '{0, 2, 4, 5, 6, 8, 10, 0, 0, 0, 0, 0}, '{0, 2, 5, 7, 10, 0, 0, 0, 0, 0, 0, 0},
        '{0, 2, 3, 7, 9, 0, 0, 0, 0, 0, 0, 0}, '{0, 1, 3, 7, 8, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 5, 7, 8, 0, 0, 0, 0, 0, 0, 0}, '{0, 4, 5, 7, 11, 0, 0, 0, 0, 0, 0, 0},
        '{0, 2, 4, 6, 8, 10, 0, 0, 0, 0, 0, 0}, '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11}
      };
      sizes = '{7, 7, 7, 5, 5, 6, 7, 3, 3, 4, 4, 7, 8, 7, 7, 5, 5, 5, 5, 5, 6, 12};
      scale_sel = 0;
      root      = 60;
      errors    = 0;
    endfunction

    function void set_reg(logic reg_idx, int value);
      if (reg_idx == REG_SCALE_SELECT) scale_sel = value & 'h1F;
      else root = value & 'h7F;
    endfunction

    // pitch class of note relative to the root, looked up in the mask
    function int pc_hit(int rel, int note);
      int d;
      d = (note - root) % 12;
      if (d < 0) d += 12;
      return (rel >> d) & 1;
    endfunction

    function out_word_t quantize(in_word_t w);
      int        sel, len, rel, deg, oct, idx, mapped, note, snapped, rpc, mask;
      bit        found;
      out_word_t r;
      sel = (scale_sel > 21) ? 21 : scale_sel;
      len = sizes[sel];
      rel = 0;
      for (int i = 0; i < len; i++) rel |= 1 << offsets[sel][i];
      // degree to note with floor division
      deg = $signed(w.raw_degree);
      oct = deg / len;
      idx = deg % len;
      if (idx < 0) begin
        idx += len;
        oct -= 1;
      end
      mapped = root + offsets[sel][idx] + oct * 12;
      if (mapped < 0) mapped = 0;
      if (mapped > 127) mapped = 127;
      // nearest scale note, upper side first
      note    = w.note_in;
      snapped = note;
      found   = pc_hit(rel, note) != 0;
      for (int k = 1; k <= 6 && !found; k++) begin
        if (note + k <= 127 && pc_hit(rel, note + k) != 0) begin
          snapped = note + k;
          found   = 1'b1;
        end else if (note - k >= 0 && pc_hit(rel, note - k) != 0) begin
          snapped = note - k;
          found   = 1'b1;
        end
      end
      // mask rotated to the root pitch class
      rpc  = root % 12;
      mask = ((rel << rpc) | (rel >> (12 - rpc))) & 'hFFF;
      r.mapped_note  = mapped[6:0];
      r.in_scale     = pc_hit(rel, note) != 0;
      r.snapped_note = snapped[6:0];
      r.scale_mask   = mask[11:0];
      return r;
    endfunction

    function void note_input(in_word_t w);
      expected_q.push_back(quantize(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word with no input waiting: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.mapped_note !== want.mapped_note) begin
        $error("mapped_note: expected %0d, actual %0d", want.mapped_note, got.mapped_note);
        errors++;
      end
      if (got.in_scale !== want.in_scale) begin
        $error("in_scale: expected %0b, actual %0b", want.in_scale, got.in_scale);
        errors++;
      end
      if (got.snapped_note !== want.snapped_note) begin
        $error("snapped_note: expected %0d, actual %0d", want.snapped_note, got.snapped_note);
        errors++;
      end
      if (got.scale_mask !== want.scale_mask) begin
        $error("scale_mask: expected %h, actual %h", want.scale_mask, got.scale_mask);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;
  bit                    calm      = 1'b0;

  note_scoreboard sb = new();

  scale_note_quantizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls, none during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 17);
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // setup then access cycle, then the bus returns to idle
  task automatic cfg_write(input logic reg_idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(reg_idx, value);
    @(posedge clk);
  endtask

  task automatic set_scale(input int sel, input int root);
    cfg_write(REG_SCALE_SELECT, sel);
    cfg_write(REG_ROOT_NOTE, root);
  endtask

  // one input word, with an optional idle gap ahead of it
  task automatic send_word(input in_word_t w);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic in_word_t make_word(input int deg, input int note);
    in_word_t w;
    w.raw_degree = deg[8:0];
    w.note_in    = note[6:0];
    return w;
  endfunction

  // mostly in-range degrees, some full range and saturating extremes
  function automatic in_word_t rand_word();
    int pick, deg, note;
    pick = $urandom_range(0, 9);
    if (pick < 6) deg = $urandom_range(0, 80) - 40;
    else if (pick < 9) deg = $urandom_range(0, 511) - 256;
    else deg = $urandom_range(0, 1) ? 255 : -256;
    note = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 127 : 0)
                                        : $urandom_range(0, 127);
    return make_word(deg, note);
  endfunction

  int dir_deg[12]  = '{-256, 255, 0, -1, 1, -7, 7, -100, 100, -2, 11, -12};
  int dir_note[12] = '{0, 127, 60, 1, 126, 61, 66, 5, 122, 64, 0, 127};

  // main sequence
  initial begin
    int sel, root;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: triad at the top root, then an out-of-range scale at root 0
    set_scale(7, 127);
    foreach (dir_deg[i]) send_word(make_word(dir_deg[i], dir_note[i]));
    drain();
    set_scale(31, 0);
    foreach (dir_deg[i]) send_word(make_word(dir_deg[i], dir_note[i]));
    drain();

    // random: every scale once, then two out-of-range selects
    for (int p = 0; p < 24; p++) begin
      sel  = (p < 22) ? p : ((p == 22) ? 22 : 31);
      root = (p == 0) ? 0 : ((p == 1) ? 127 : $urandom_range(0, 127));
      set_scale(sel, root);
      calm = (p == 10 || p == 11);
      for (int n = 0; n < 71; n++) send_word(rand_word());
      drain();
    end

    if (sb.errors == 0) begin
      $display("scale_note_quantizer_core_test: PASS");
    end else begin
      $display("scale_note_quantizer_core_test: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("scale_note_quantizer_core_test: FAIL");
    $finish;
  end

endmodule
